/* rtl/core/sbcd_pkg.sv */
// ----------------------------------------------------------------------------
// sbcd_pkg
// Types, codes and segment table shared by the BCD counter with error flash.
// ----------------------------------------------------------------------------
`default_nettype none

package sbcd_pkg;

   localparam logic [1:0] PHASE_NONE = 2'd0;
   localparam logic [1:0] PHASE_ON   = 2'd1;
   localparam logic [1:0] PHASE_OFF  = 2'd2;

   localparam logic [1:0] BEEP_NONE = 2'd0;
   localparam logic [1:0] BEEP_INC  = 2'd1;
   localparam logic [1:0] BEEP_DEC  = 2'd2;
   localparam logic [1:0] BEEP_ERR  = 2'd3;

   localparam logic [7:0] SEG_MID_BAR = 8'hF7;
   localparam logic [7:0] SEG_BLANK   = 8'hFF;

   localparam logic       OP_TICK   = 1'b0;
   localparam logic       OP_BUTTON = 1'b1;

   localparam logic [0:0] CSR_FLASH_PERIOD = 1'd0;
   localparam logic [0:0] CSR_FLASH_COUNT  = 1'd1;

   localparam logic [9:0] FLASH_PERIOD_RESET = 10'd100;
   localparam logic [3:0] FLASH_COUNT_RESET  = 4'd3;

   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef struct packed {
      logic       operation;
      logic [3:0] buttons;
   } sbcd_req_type;

   typedef struct packed {
      logic [7:0] seg_left;
      logic [7:0] seg_right;
      logic [1:0] beep;
      logic       flashing;
      logic [3:0] units_value;
      logic [3:0] tenths_value;
   } sbcd_rsp_type;

   typedef struct packed {
      logic [9:0] flash_period;
      logic [3:0] flash_count;
   } sbcd_cfg_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h08;
         4'd1:    code = 8'h6B;
         4'd2:    code = 8'h44;
         4'd3:    code = 8'h41;
         4'd4:    code = 8'h23;
         4'd5:    code = 8'h11;
         4'd6:    code = 8'h10;
         4'd7:    code = 8'h4B;
         4'd8:    code = 8'h00;
         4'd9:    code = 8'h03;
         default: code = SEG_BLANK;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/saturating_bcd_counter_error_flash.sv */
// ----------------------------------------------------------------------------
// saturating_bcd_counter_error_flash
// Two-digit 0.0 to 9.9 counter driven by ticks and button edges, with an
// error flash on out-of-range steps and seven-segment outputs.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while results are taken, and returns exactly
// one result per item. The item is first held in the input register; the
// state update and the result register load then happen together at the same
// edge, and rsp_valid rises as the result register loads. A full result
// register that is not taken stalls both. The state update touches the digit
// and flash registers once per item. The user must write csr_data only while
// the block is idle; the block itself does not enforce it. flash_period is
// used from bits [9:0] and flash_count from bits [3:0].
`default_nettype none

module saturating_bcd_counter_error_flash (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sbcd_pkg::sbcd_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sbcd_pkg::sbcd_rsp_type    rsp_data,
   input  wire logic                 csr_write_enable,
   input  wire logic [0:0]           csr_index,
   input  wire logic [9:0]           csr_data
);
   import sbcd_pkg::*;

   sbcd_cfg_type cfg_ff;
   logic         item_valid_ff;
   sbcd_req_type item_ff;
   logic         load_ok;
   logic         step_en;
   sbcd_rsp_type result;

   assign step_en   = item_valid_ff && load_ok;
   assign req_ready = !item_valid_ff || load_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_period <= FLASH_PERIOD_RESET;
         cfg_ff.flash_count  <= FLASH_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FLASH_PERIOD: cfg_ff.flash_period <= csr_data;
            CSR_FLASH_COUNT:  cfg_ff.flash_count  <= csr_data[3:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // hold the item until the result register can take it
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_data;
      end
   end

   sbcd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   sbcd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid_ff),
      .load_data  (result),
      .load_ok    (load_ok),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/sbcd_core.sv */
// ----------------------------------------------------------------------------
// sbcd_core
// Digit and flash state with the per-item update and result formation.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcd_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire sbcd_pkg::sbcd_req_type item,
   input  wire sbcd_pkg::sbcd_cfg_type cfg,
   output sbcd_pkg::sbcd_rsp_type    result
);
   import sbcd_pkg::*;

   logic [3:0] units_ff, units_in;
   logic [3:0] tenths_ff, tenths_in;
   logic [1:0] phase_ff, phase_in;
   logic [9:0] ticks_ff, ticks_in;
   logic [3:0] rounds_ff, rounds_in;
   logic [1:0] beep;
   logic       running;
   logic       running_next;
   logic       start_flash;

   always_comb begin
      units_in    = units_ff;
      tenths_in   = tenths_ff;
      phase_in    = phase_ff;
      ticks_in    = ticks_ff;
      rounds_in   = rounds_ff;
      beep        = BEEP_NONE;
      start_flash = 1'b0;
      running     = (phase_ff == PHASE_ON) || (phase_ff == PHASE_OFF);

      if (item.operation == OP_TICK) begin
         if (!running) begin
            phase_in = PHASE_NONE;
         end else if (ticks_ff > 10'd1) begin
            ticks_in = ticks_ff - 10'd1;
         end else if (phase_ff == PHASE_ON) begin
            phase_in = PHASE_OFF;
            ticks_in = cfg.flash_period;
         end else begin
            rounds_in = rounds_ff + 4'd1;
            if (rounds_in >= cfg.flash_count || rounds_in == 4'd0) begin
               phase_in = PHASE_NONE;
               ticks_in = '0;
            end else begin
               phase_in = PHASE_ON;
               ticks_in = cfg.flash_period;
               beep     = BEEP_ERR;
            end
         end
      end else if (!running) begin
         if (item.buttons[0]) begin
            if (units_ff < DIGIT_MAX) begin
               units_in = units_ff + 4'd1;
               beep     = BEEP_INC;
            end else begin
               start_flash = 1'b1;
            end
         end else if (item.buttons[1]) begin
            if (units_ff != 4'd0) begin
               units_in = units_ff - 4'd1;
               beep     = BEEP_DEC;
            end else begin
               start_flash = 1'b1;
            end
         end else if (item.buttons[2]) begin
            if (units_ff == DIGIT_MAX && tenths_ff == DIGIT_MAX) begin
               start_flash = 1'b1;
            end else begin
               beep = BEEP_INC;
               if (tenths_ff >= DIGIT_MAX) begin
                  tenths_in = '0;
                  if (units_ff < DIGIT_MAX) begin
                     units_in = units_ff + 4'd1;
                  end
               end else begin
                  tenths_in = tenths_ff + 4'd1;
               end
            end
         end else if (item.buttons[3]) begin
            if (units_ff == 4'd0 && tenths_ff == 4'd0) begin
               start_flash = 1'b1;
            end else begin
               beep = BEEP_DEC;
               if (tenths_ff == 4'd0) begin
                  tenths_in = DIGIT_MAX;
                  if (units_ff != 4'd0) begin
                     units_in = units_ff - 4'd1;
                  end
               end else begin
                  tenths_in = tenths_ff - 4'd1;
               end
            end
         end
         if (start_flash) begin
            phase_in  = PHASE_ON;
            ticks_in  = cfg.flash_period;
            rounds_in = '0;
            beep      = BEEP_ERR;
         end
      end

      running_next = (phase_in == PHASE_ON) || (phase_in == PHASE_OFF);
      result.beep         = beep;
      result.flashing     = running_next;
      result.units_value  = units_in;
      result.tenths_value = tenths_in;
      if (phase_in == PHASE_ON) begin
         result.seg_left  = SEG_MID_BAR;
         result.seg_right = SEG_MID_BAR;
      end else if (phase_in == PHASE_OFF) begin
         result.seg_left  = SEG_BLANK;
         result.seg_right = SEG_BLANK;
      end else begin
         result.seg_left  = seg_code(units_in);
         result.seg_right = seg_code(tenths_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         units_ff  <= '0;
         tenths_ff <= '0;
         phase_ff  <= PHASE_NONE;
         ticks_ff  <= '0;
         rounds_ff <= '0;
      end else if (step_en) begin
         units_ff  <= units_in;
         tenths_ff <= tenths_in;
         phase_ff  <= phase_in;
         ticks_ff  <= ticks_in;
         rounds_ff <= rounds_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sbcd_out_reg.sv */
// ----------------------------------------------------------------------------
// sbcd_out_reg
// Result register with valid and ready towards the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcd_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load_valid,
   input  wire sbcd_pkg::sbcd_rsp_type load_data,
   output logic                      load_ok,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sbcd_pkg::sbcd_rsp_type    rsp_data
);
   import sbcd_pkg::*;

   logic         valid_ff;
   sbcd_rsp_type data_ff;

   assign load_ok   = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ok) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sbcd_checker.sv */
// ----------------------------------------------------------------------------
// sbcd_checker
// Port-level checks on the BCD counter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sbcd_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire sbcd_pkg::sbcd_rsp_type rsp_data
);
   import sbcd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("item changed while stalled");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.units_value <= DIGIT_MAX
                    && rsp_data.tenths_value <= DIGIT_MAX)
      else $error("digit out of range");

   a_flash_segs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flashing |->
         (rsp_data.seg_left == SEG_MID_BAR && rsp_data.seg_right == SEG_MID_BAR)
         || (rsp_data.seg_left == SEG_BLANK && rsp_data.seg_right == SEG_BLANK))
      else $error("flash shows digit codes");

   a_err_beep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.beep == BEEP_ERR |-> rsp_data.flashing
         && rsp_data.seg_left == SEG_MID_BAR)
      else $error("error beep outside an on phase");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind saturating_bcd_counter_error_flash sbcd_checker u_sbcd_checker (.*);

`default_nettype wire
